// ===== src/tsia_pkg.sv =====
// Shared types and constants for the tagged small-integer ALU.
package tsia_pkg;

  localparam int WORD_W   = 32;
  localparam int SHAMT_W  = $clog2(WORD_W);
  localparam int OP_W     = 4;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 2 * WORD_W;
  localparam int IN_TUSER_W  = OP_W;
  localparam int OUT_TDATA_W = WORD_W;
  localparam int OUT_TUSER_W = 1 + STATUS_W;

  localparam logic [OP_W-1:0] OP_LT        = 4'd0;
  localparam logic [OP_W-1:0] OP_GT        = 4'd1;
  localparam logic [OP_W-1:0] OP_LE        = 4'd2;
  localparam logic [OP_W-1:0] OP_GE        = 4'd3;
  localparam logic [OP_W-1:0] OP_EQ        = 4'd4;
  localparam logic [OP_W-1:0] OP_NE        = 4'd5;
  localparam logic [OP_W-1:0] OP_AND       = 4'd6;
  localparam logic [OP_W-1:0] OP_OR        = 4'd7;
  localparam logic [OP_W-1:0] OP_XOR       = 4'd8;
  localparam logic [OP_W-1:0] OP_SHIFT     = 4'd9;
  localparam logic [OP_W-1:0] OP_RAW_SHIFT = 4'd10;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_WRONG_TYPE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [WORD_W-1:0] receiver_word;
    logic [WORD_W-1:0] argument_word;
  } tsia_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]   result_word;
    logic                condition;
    logic [STATUS_W-1:0] status;
  } tsia_result_t;

endpackage

// ===== src/tsia_alu.sv =====
// Single-pass datapath for one tagged small-integer primitive.
module tsia_alu #(
  parameter int TAG_BITS = 2
) (
  input  tsia_pkg::tsia_item_t   item,
  output tsia_pkg::tsia_result_t res
);
  import tsia_pkg::*;

  localparam logic [WORD_W-1:0] TAG_MASK    = WORD_W'((1 << TAG_BITS) - 1);
  localparam logic [WORD_W-1:0] TAG_CLEAR   = ~TAG_MASK;
  localparam logic [WORD_W-1:0] MAX_SHIFT_W = WORD_W'(WORD_W - TAG_BITS - 1);

  logic [WORD_W-1:0]        r;
  logic [WORD_W-1:0]        a;
  logic signed [WORD_W-1:0] n;
  logic [WORD_W-1:0]        neg_n;
  logic [SHAMT_W-1:0]       k;
  logic [SHAMT_W-1:0]       d;
  logic [WORD_W-1:0]        lsh;
  logic                     lsh_ok;
  logic                     wrong;

  always_comb begin
    r      = item.receiver_word;
    a      = item.argument_word;
    n      = $signed(a) >>> TAG_BITS;
    neg_n  = -n;
    k      = n[SHAMT_W-1:0];
    d      = (neg_n > MAX_SHIFT_W) ? MAX_SHIFT_W[SHAMT_W-1:0] : neg_n[SHAMT_W-1:0];
    lsh    = r << k;
    lsh_ok = (($signed(lsh) >>> k) == $signed(r));
    wrong  = (item.operation inside {[OP_LT:OP_RAW_SHIFT]}) && ((a & TAG_MASK) != '0);

    res.result_word = '0;
    res.condition   = 1'b0;
    res.status      = ST_OK;

    if (wrong) begin
      res.status = ST_WRONG_TYPE;
    end else begin
      case (item.operation)
        OP_LT:  res.condition = ($signed(r) <  $signed(a));
        OP_GT:  res.condition = ($signed(r) >  $signed(a));
        OP_LE:  res.condition = ($signed(r) <= $signed(a));
        OP_GE:  res.condition = ($signed(r) >= $signed(a));
        OP_EQ:  res.condition = (r == a);
        OP_NE:  res.condition = (r != a);
        OP_AND: res.result_word = r & a;
        OP_OR:  res.result_word = r | a;
        OP_XOR: res.result_word = r ^ a;
        OP_SHIFT: begin
          if (n > 0) begin
            if ((n < $signed(MAX_SHIFT_W)) && lsh_ok) begin
              res.result_word = lsh;
            end else begin
              res.status = ST_OVERFLOW;
            end
          end else begin
            res.result_word = WORD_W'($signed(r) >>> d) & TAG_CLEAR;
          end
        end
        OP_RAW_SHIFT: begin
          if (n >= 0) begin
            res.result_word = r << n[SHAMT_W-1:0];
          end else begin
            res.result_word = (r >> neg_n[SHAMT_W-1:0]) & TAG_CLEAR;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/tagged_small_integer_alu.sv =====
// Top level of the tagged small-integer ALU with stream ports.
// Accepts one transaction per clock while the output is not stalled, and returns one
// result transaction for each, in order. Each accepted transaction goes to an input register that
// feeds the single-pass comparison, logic and barrel-shift datapath, whose output is held
// in a result register; throughput of one item per cycle is set by that datapath.
// A stalled result register holds, and the input register still takes a new transaction
// while it is empty.
module tagged_small_integer_alu #(
  parameter int TAG_BITS = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tsia_pkg::IN_TDATA_W-1:0]    in_tdata,  // receiver_word, argument_word
  input  logic [tsia_pkg::IN_TUSER_W-1:0]    in_tuser,  // operation
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tsia_pkg::OUT_TDATA_W-1:0]   out_tdata, // result_word
  output logic [tsia_pkg::OUT_TUSER_W-1:0]   out_tuser  // condition, status
);
  import tsia_pkg::*;

  logic         s1_valid_r;
  logic         s1_valid_nxt;
  tsia_item_t   s1_item_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  tsia_result_t out_res_r;
  tsia_result_t alu_res;
  logic         in_take;
  logic         s1_move;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = in_take || (s1_valid_r && !s1_move);
    out_valid_nxt = s1_move || (out_valid_r && !out_tready);
  end

  tsia_alu #(
    .TAG_BITS (TAG_BITS)
  ) u_tsia_alu (
    .item (s1_item_r),
    .res  (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.operation     <= in_tuser;
      s1_item_r.receiver_word <= in_tdata[WORD_W-1:0];
      s1_item_r.argument_word <= in_tdata[2*WORD_W-1:WORD_W];
    end
    if (s1_move) begin
      out_res_r <= alu_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.result_word;
  assign out_tuser  = {out_res_r.status, out_res_r.condition};

endmodule

// ===== src/tsia_checker.sv =====
// Port-level checks for the tagged small-integer ALU, bound to its top level.
module tsia_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [tsia_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [tsia_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import tsia_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result transaction changed");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[OUT_TUSER_W-1:1] != ST_OK)
      |-> (out_tdata == '0) && !out_tuser[0])
    else $error("error status with nonzero payload");

  a_cond_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == '0))
    else $error("comparison true with nonzero result word");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input not ready while result register empty");

endmodule

bind tagged_small_integer_alu tsia_checker u_tsia_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== sim/tsia_result_checker.sv =====
`timescale 1ns / 100ps
// Checker for the tagged small-integer ALU: predicts each result and compares it on the output.
module tsia_result_checker
  import tsia_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // receiver_word, argument_word
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // operation
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // result_word
  input  logic [OUT_TUSER_W-1:0] out_tuser,  // condition, status
  output int                     fail_count,
  output int                     pending_count
);

  localparam int TAG_BITS = 2;
  localparam int MAX_SHIFT = WORD_W - TAG_BITS - 1;
  localparam logic [WORD_W-1:0] TAG_CLEAR = {WORD_W{1'b1}} << TAG_BITS;

  tsia_result_t expected_results[$];

  function automatic tsia_result_t predict_alu_result(input logic [OP_W-1:0] op,
                                                      input logic [WORD_W-1:0] rw,
                                                      input logic [WORD_W-1:0] aw);
    tsia_result_t res;
    int n;
    int shamt;
    logic [WORD_W-1:0] m1;
    logic [WORD_W-1:0] m2;
    logic signed [WORD_W-1:0] sra;
    res = '0;
    n = $signed(aw) >>> TAG_BITS;
    if (op <= OP_RAW_SHIFT && (aw & ~TAG_CLEAR) != '0) begin
      res.status = ST_WRONG_TYPE;
    end else begin
      case (op)
        OP_LT: res.condition = $signed(rw) < $signed(aw);
        OP_GT: res.condition = $signed(rw) > $signed(aw);
        OP_LE: res.condition = $signed(rw) <= $signed(aw);
        OP_GE: res.condition = $signed(rw) >= $signed(aw);
        OP_EQ: res.condition = rw == aw;
        OP_NE: res.condition = rw != aw;
        OP_AND: res.result_word = rw & aw;
        OP_OR: res.result_word = rw | aw;
        OP_XOR: res.result_word = rw ^ aw;
        OP_SHIFT: begin
          if (n > 0) begin
            if (n < MAX_SHIFT) begin
              m1 = 32'd1 << (WORD_W - (n + 1));
              m2 = {WORD_W{1'b1}} << (WORD_W - n);
              if (((rw + m1) & m2) == '0) res.result_word = rw << n;
              else res.status = ST_OVERFLOW;
            end else begin
              res.status = ST_OVERFLOW;
            end
          end else begin
            shamt = -n;
            if (shamt > MAX_SHIFT) shamt = MAX_SHIFT;
            sra = $signed(rw) >>> shamt;
            res.result_word = sra & TAG_CLEAR;
          end
        end
        OP_RAW_SHIFT: begin
          if (n >= 0) res.result_word = rw << (n % WORD_W);
          else res.result_word = (rw >> ((-n) % WORD_W)) & TAG_CLEAR;
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    tsia_result_t want;
    tsia_result_t got;
    int errs;
    errs = 0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.result_word = out_tdata;
        got.condition = out_tuser[0];
        got.status = out_tuser[2:1];
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: result_word %h condition %0d status %0d",
                 got.result_word, got.condition, got.status);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (got.result_word !== want.result_word) begin
            $error("result_word: expected %h, actual %h", want.result_word, got.result_word);
            errs++;
          end
          if (got.condition !== want.condition) begin
            $error("condition: expected %0d, actual %0d", want.condition, got.condition);
            errs++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_alu_result(in_tuser, in_tdata[WORD_W-1:0],
                                                      in_tdata[2*WORD_W-1:WORD_W]));
    end
    fail_count <= fail_count + errs;
    pending_count <= expected_results.size();
  end

endmodule

// ===== sim/tb_tagged_small_integer_alu.sv =====
`timescale 1ns / 100ps
// Testbench top for the tagged small-integer ALU: clock, reset, stimulus and verdict.
module tb_tagged_small_integer_alu;
  import tsia_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD = 200;
  localparam int RANDOM_ITEMS = 1100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;   // receiver_word, argument_word
  logic [IN_TUSER_W-1:0] in_tuser = '0;   // operation
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // result_word
  logic [OUT_TUSER_W-1:0] out_tuser;      // condition, status

  int fail_count;
  int pending_count;
  int items_sent = 0;
  int burst_left = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  tagged_small_integer_alu u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  tsia_result_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .fail_count(fail_count), .pending_count(pending_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // hold off once for a long stretch, otherwise stall on a changing pattern
  initial begin
    int phase;
    int stall_mode;
    bit long_hold_done;
    phase = 0;
    stall_mode = 0;
    long_hold_done = 0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (!long_hold_done && items_sent >= 600) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1;
      end else begin
        phase++;
        if (phase % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= $urandom_range(0, 9) != 0;
          default: out_tready <= (phase % 4) != 3;
        endcase
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] rw,
                           input logic [WORD_W-1:0] aw);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {aw, rw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        in_tdata <= {$urandom, $urandom};
        in_tuser <= OP_W'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] w;
    int width;
    case ($urandom_range(0, 4))
      0, 1: w = $urandom;
      2: begin
        width = $urandom_range(1, 31);
        w = $signed($urandom << (WORD_W - width)) >>> (WORD_W - width);
      end
      3: begin
        case ($urandom_range(0, 5))
          0: w = 32'h0000_0000;
          1: w = 32'hFFFF_FFFF;
          2: w = 32'h8000_0000;
          3: w = 32'h7FFF_FFFF;
          4: w = 32'h7FFF_FFFC;
          default: w = 32'h8000_0004;
        endcase
      end
      default: w = $urandom_range(0, 255);
    endcase
    return w;
  endfunction

  initial begin
    logic [OP_W-1:0] op;
    logic [WORD_W-1:0] rw;
    logic [WORD_W-1:0] aw;
    int n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_LT, 32'h8000_0000, 32'h7FFF_FFFC);
    send_item(OP_GT, 32'hFFFF_FFFC, 32'h0000_0004);
    send_item(OP_LE, 32'h7FFF_FFFC, 32'h7FFF_FFFC);
    send_item(OP_GE, 32'h0000_0000, 32'h8000_0000);
    send_item(OP_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFC);
    send_item(OP_NE, 32'h1234_5678, 32'h1234_5678);
    send_item(OP_AND, 32'hFFFF_FFFF, 32'hA5A5_A5A4);
    send_item(OP_OR, 32'h0000_0003, 32'h5A5A_5A58);
    send_item(OP_XOR, 32'hFFFF_FFFF, 32'hFFFF_FFFC);
    send_item(OP_AND, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(OP_LT, 32'h0000_0000, 32'h8000_0002);
    send_item(OP_SHIFT, 32'h0000_0004, 32'hFFFF_FFFF);
    send_item(4'd11, 32'h1234_5678, 32'h0000_0007);
    send_item(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_SHIFT, 32'h0000_0004, 32'd28 << 2);
    send_item(OP_SHIFT, 32'h0000_0008, 32'd28 << 2);
    send_item(OP_SHIFT, 32'hFFFF_FFFC, 32'd1 << 2);
    send_item(OP_SHIFT, 32'h4000_0000, 32'd1 << 2);
    send_item(OP_SHIFT, 32'h0000_0000, 32'd29 << 2);
    send_item(OP_SHIFT, 32'h8000_0000, 32'hFFFF_FF88);
    send_item(OP_SHIFT, 32'h7FFF_FFFF, 32'h0000_0000);
    send_item(OP_SHIFT, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_RAW_SHIFT, 32'h0000_0001, 32'd33 << 2);
    send_item(OP_RAW_SHIFT, 32'hFFFF_FFFF, 32'hFFFF_FFFC);
    send_item(OP_RAW_SHIFT, 32'hFFFF_FFFF, 32'hFFFF_FF80);
    send_item(OP_RAW_SHIFT, 32'hFFFF_FFFF, 32'd31 << 2);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      op = ($urandom_range(0, 99) < 5) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
      rw = random_word();
      if (op == OP_SHIFT || op == OP_RAW_SHIFT) begin
        if ($urandom_range(0, 9) < 8) n = $urandom_range(0, 80) - 40;
        else n = $signed($urandom) >>> 2;
        aw = n << 2;
      end else if ($urandom_range(0, 3) == 0) begin
        aw = rw & ({WORD_W{1'b1}} << 2);
      end else begin
        aw = random_word() & ({WORD_W{1'b1}} << 2);
      end
      if ($urandom_range(0, 9) == 0) aw[1:0] = 2'($urandom_range(1, 3));
      send_item(op, rw, aw);
      if (i == RANDOM_ITEMS / 3) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      if (pending_count != 0) $error("%0d expected results never arrived", pending_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
